// ===== rtl/core/frmc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the first-match range rule classifier: rule and query types,
// item kind codes and sizing constants. Depends on nothing.

package frmc_pkg;

	localparam int RULE_SLOTS_DEF = 256;
	localparam int COUNT_W        = 9;
	localparam int SLOT_W         = 8;
	localparam int LANDUSE_W      = 12;
	localparam int CLASS_W        = 12;
	localparam int VALUE_W        = 16;

	// item kind codes
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// one stored rule
	typedef struct packed {
		logic [CLASS_W-1:0]          class_code;
		logic [VALUE_W-1:0]          rain_hi;
		logic [VALUE_W-1:0]          rain_lo;
		logic signed [VALUE_W-1:0]   temp_hi;
		logic signed [VALUE_W-1:0]   temp_lo;
		logic                        landuse_any;
		logic [LANDUSE_W-1:0]        landuse;
	} rule_t;

	// key of one query
	typedef struct packed {
		logic [LANDUSE_W-1:0]        landuse;
		logic                        landuse_any;
		logic signed [VALUE_W-1:0]   temp;
		logic [VALUE_W-1:0]          rain;
	} query_t;

endpackage

// ===== rtl/core/frmc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the classifier: item words in, result words out.
// Depends on frmc_pkg.

interface frmc_item_if
	import frmc_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [SLOT_W-1:0]           slot;
	logic [LANDUSE_W-1:0]        landuse;
	logic                        landuse_any;
	logic signed [VALUE_W-1:0]   temp_lo;
	logic signed [VALUE_W-1:0]   temp_hi;
	logic [VALUE_W-1:0]          rain_lo;
	logic [VALUE_W-1:0]          rain_hi;
	logic [CLASS_W-1:0]          class_code;
	logic signed [VALUE_W-1:0]   query_temp;
	logic [VALUE_W-1:0]          query_rain;

	modport source (
		output valid, kind, slot, landuse, landuse_any, temp_lo, temp_hi,
		       rain_lo, rain_hi, class_code, query_temp, query_rain,
		input  ready
	);
	modport sink (
		input  valid, kind, slot, landuse, landuse_any, temp_lo, temp_hi,
		       rain_lo, rain_hi, class_code, query_temp, query_rain,
		output ready
	);
endinterface

interface frmc_result_if
	import frmc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [CLASS_W-1:0]   result_class;
	logic [SLOT_W-1:0]    hit_slot;

	modport source (output valid, found, result_class, hit_slot, input ready);
	modport sink (input valid, found, result_class, hit_slot, output ready);
endinterface

// ===== rtl/core/first_match_range_rule_classifier.sv =====
`timescale 1ns / 1ps
// First-match range rule classifier. A write word stores a rule and the block is ready
// again at once. A query word scans slots 0 to n-1, n being rule_count capped at
// RULE_SLOTS, one rule per cycle through the single read port of the rule table and one
// shared compare unit; it stops at the first hit. A query holds the input from its accept
// through the scan and the load of the result register, which waits while the result
// register is still full. The result register lets a query's answer wait for its taker
// while rules are written; a second query's answer waits in the scan unit until the first
// is taken. Depends on frmc_pkg, frmc_if, frmc_rule_mem and frmc_match.

module first_match_range_rule_classifier
	import frmc_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_data,
	frmc_item_if.sink           item,
	frmc_result_if.source       result
);

	localparam int ADDR_W = $clog2(RULE_SLOTS);
	localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
	localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   rule_count_q;
	query_t               query_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 pend_q;
	logic [ADDR_W-1:0]    idx_s1;
	logic                 found_q;
	logic [CLASS_W-1:0]   class_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 out_valid_q;
	logic                 out_found_q;
	logic [CLASS_W-1:0]   out_class_q;
	logic [SLOT_W-1:0]    out_slot_q;

	logic                 in_acc;
	logic                 wr_en;
	rule_t                wr_rule;
	logic                 rd_en;
	rule_t                rd_rule;
	logic                 hit;
	logic [CNT_W-1:0]     n_sat;
	logic                 more;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
		end else if (cfg_we) begin
			rule_count_q <= cfg_data;
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign in_acc     = item.valid & item.ready;

	// rule write, slots past the table are dropped
	assign wr_en = in_acc && (item.kind == KIND_WRITE)
		&& (LIM_W'(item.slot) < LIM_W'(RULE_SLOTS));
	assign wr_rule = '{
		class_code:  item.class_code,
		rain_hi:     item.rain_hi,
		rain_lo:     item.rain_lo,
		temp_hi:     item.temp_hi,
		temp_lo:     item.temp_lo,
		landuse_any: item.landuse_any,
		landuse:     item.landuse
	};

	// scan length capped at the table size
	assign n_sat = (LIM_W'(rule_count_q) > LIM_W'(RULE_SLOTS))
		? CNT_W'(RULE_SLOTS) : CNT_W'(rule_count_q);

	assign more  = (rd_idx_q < n_q);
	assign rd_en = (state_q == ST_SCAN) && !(pend_q && hit) && more;

	frmc_rule_mem #(
		.RULE_SLOTS(RULE_SLOTS)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ADDR_W'(item.slot)),
		.wdata (wr_rule),
		.re    (rd_en),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (rd_rule)
	);

	frmc_match u_match (
		.rule  (rd_rule),
		.query (query_q),
		.hit   (hit)
	);

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_q   <= 1'b0;
			rd_idx_q <= '0;
			n_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (item.kind == KIND_QUERY)) begin
						n_q      <= n_sat;
						rd_idx_q <= '0;
						pend_q   <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pend_q && hit) begin
						pend_q  <= 1'b0;
						state_q <= ST_DONE;
					end else if (more) begin
						pend_q   <= 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query key, slot in flight and answer
	always_ff @(posedge clk) begin
		if (in_acc && (item.kind == KIND_QUERY)) begin
			query_q <= '{
				landuse:     item.landuse,
				landuse_any: item.landuse_any,
				temp:        item.query_temp,
				rain:        item.query_rain
			};
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q[ADDR_W-1:0];
		end
		if (state_q == ST_SCAN) begin
			if (pend_q && hit) begin
				found_q <= 1'b1;
				class_q <= rd_rule.class_code;
				slot_q  <= SLOT_W'(idx_s1);
			end else if (!more && !pend_q) begin
				found_q <= 1'b0;
				class_q <= '0;
				slot_q  <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || result.ready)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || result.ready)) begin
			out_found_q <= found_q;
			out_class_q <= class_q;
			out_slot_q  <= slot_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = out_found_q;
	assign result.result_class = out_class_q;
	assign result.hit_slot     = out_slot_q;

	// scan never reads past the capped count
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= n_q))
		else $error("scan index beyond rule count");

	// a hit comes only from a slot inside the scanned range
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && pend_q) |-> (CNT_W'(idx_s1) < n_q))
		else $error("compared slot outside scanned range");

	// an accepted query starts a scan
	a_query_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && item.kind == KIND_QUERY) |=> (state_q == ST_SCAN))
		else $error("query accepted without scan");

	// a miss reports zero class and slot
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_class_q == '0 && out_slot_q == '0))
		else $error("miss with nonzero class or slot");

endmodule

// ===== rtl/core/frmc_rule_mem.sv =====
`timescale 1ns / 1ps
// Rule table: one write port, one read port with registered read data.
// Depends on frmc_pkg.

module frmc_rule_mem
	import frmc_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF,
	localparam int ADDR_W = $clog2(RULE_SLOTS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  rule_t             wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output rule_t             rdata
);

	rule_t mem_q [RULE_SLOTS];
	rule_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/frmc_match.sv =====
`timescale 1ns / 1ps
// Shared rule compare unit: tests one rule against the current query per cycle.
// Depends on frmc_pkg.

module frmc_match
	import frmc_pkg::*;
(
	input  rule_t  rule,
	input  query_t query,
	output logic   hit
);

	logic landuse_ok;
	logic temp_ok;
	logic rain_ok;

	// wildcard on either side, else exact code
	assign landuse_ok = rule.landuse_any | query.landuse_any
		| (rule.landuse == query.landuse);

	// equal bounds mean don't care; signed range for temperature
	assign temp_ok = (rule.temp_lo == rule.temp_hi)
		| (($signed(rule.temp_lo) <= $signed(query.temp))
		&& ($signed(query.temp) <= $signed(rule.temp_hi)));

	// unsigned range for rainfall
	assign rain_ok = (rule.rain_lo == rule.rain_hi)
		| ((rule.rain_lo <= query.rain) && (query.rain <= rule.rain_hi));

	assign hit = landuse_ok & temp_ok & rain_ok;

endmodule

// ===== bench/first_match_range_rule_classifier_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the first-match range rule classifier: rule writes and table
// queries on the item channel, answers scored against fixed expectations or a behavioural
// rule-table shadow. Depends on frmc_pkg, frmc_if and the classifier RTL.

module first_match_range_rule_classifier_tb;
	import frmc_pkg::*;

	localparam int RULE_SLOTS   = RULE_SLOTS_DEF;
	localparam int CLK_HALF     = 10;
	localparam int TARGET_WORDS = 1900;
	localparam int IDLE_PCT     = 17;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;
	localparam int MAX_COUNT    = (1 << COUNT_W) - 1;

	// one word on the item channel
	typedef struct packed {
		logic                      kind;
		logic [SLOT_W-1:0]         slot;
		logic [LANDUSE_W-1:0]      landuse;
		logic                      landuse_any;
		logic signed [VALUE_W-1:0] temp_lo;
		logic signed [VALUE_W-1:0] temp_hi;
		logic [VALUE_W-1:0]        rain_lo;
		logic [VALUE_W-1:0]        rain_hi;
		logic [CLASS_W-1:0]        class_code;
		logic signed [VALUE_W-1:0] query_temp;
		logic [VALUE_W-1:0]        query_rain;
	} item_word_t;

	// one word on the result channel
	typedef struct packed {
		logic               found;
		logic [CLASS_W-1:0] result_class;
		logic [SLOT_W-1:0]  hit_slot;
	} answer_t;

	// directed step: optional rule-count change, then one word
	typedef struct {
		bit                 set_count;
		logic [COUNT_W-1:0] count;
		item_word_t         w;
		bit                 typed;
		answer_t            want;
	} step_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_data;

	frmc_item_if   item_bus ();
	frmc_result_if result_bus ();

	first_match_range_rule_classifier #(.RULE_SLOTS(RULE_SLOTS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.item     (item_bus),
		.result   (result_bus)
	);

	// shadow of the rule table and the scan length
	rule_t              rule_table [RULE_SLOTS];
	bit                 slot_written [RULE_SLOTS];
	logic [COUNT_W-1:0] rule_count = '0;

	answer_t   pending_answers [$];
	step_row_t directed_steps [$];

	int words_sent     = 0;
	int queries_sent   = 0;
	int hits_seen      = 0;
	int misses_seen    = 0;
	int mismatches     = 0;
	int settings_used  = 0;
	bit steady         = 0;
	bit hold_req       = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	initial begin
		#60_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// first matching rule over slots 0 .. rule_count-1, capped at the table size
	function automatic answer_t classify(input item_word_t q);
		answer_t a;
		rule_t   r;
		int      n;
		bit      lu_ok;
		bit      t_ok;
		bit      r_ok;
		a = '0;
		n = (rule_count > RULE_SLOTS) ? RULE_SLOTS : int'(rule_count);
		for (int i = 0; i < n; i++) begin
			r = rule_table[i];
			lu_ok = r.landuse_any || q.landuse_any || (r.landuse == q.landuse);
			t_ok  = (r.temp_lo == r.temp_hi) ||
			        ($signed(r.temp_lo) <= $signed(q.query_temp) &&
			         $signed(q.query_temp) <= $signed(r.temp_hi));
			r_ok  = (r.rain_lo == r.rain_hi) ||
			        (r.rain_lo <= q.query_rain && q.query_rain <= r.rain_hi);
			if (lu_ok && t_ok && r_ok) begin
				a.found        = 1'b1;
				a.result_class = r.class_code;
				a.hit_slot     = SLOT_W'(i);
				return a;
			end
		end
		return a;
	endfunction

	// every field random
	function automatic item_word_t random_noise();
		item_word_t w;
		w.kind        = 1'($urandom);
		w.slot        = SLOT_W'($urandom);
		w.landuse     = LANDUSE_W'($urandom);
		w.landuse_any = 1'($urandom);
		w.temp_lo     = VALUE_W'($urandom);
		w.temp_hi     = VALUE_W'($urandom);
		w.rain_lo     = VALUE_W'($urandom);
		w.rain_hi     = VALUE_W'($urandom);
		w.class_code  = CLASS_W'($urandom);
		w.query_temp  = VALUE_W'($urandom);
		w.query_rain  = VALUE_W'($urandom);
		return w;
	endfunction

	// rule drawn mostly from a small land-use pool with nearby ranges
	function automatic item_word_t random_rule(input int slot);
		item_word_t w;
		int         centre;
		int         span;
		int         shape;
		w = random_noise();
		w.kind = KIND_WRITE;
		w.slot = SLOT_W'(slot);
		if ($urandom_range(99) < 15)
			return w;
		w.landuse     = LANDUSE_W'($urandom_range(7));
		w.landuse_any = ($urandom_range(99) < 15);
		// temperature: don't care, inverted or ordinary window
		centre = int'($urandom_range(600)) - 300;
		span   = $urandom_range(200);
		shape  = $urandom_range(9);
		if (shape == 0) begin
			w.temp_lo = VALUE_W'(centre);
			w.temp_hi = VALUE_W'(centre);
		end else if (shape == 1) begin
			w.temp_lo = VALUE_W'(centre + span + 1);
			w.temp_hi = VALUE_W'(centre);
		end else begin
			w.temp_lo = VALUE_W'(centre - span);
			w.temp_hi = VALUE_W'(centre + span);
		end
		// rainfall likewise
		centre = $urandom_range(300, 1000);
		span   = $urandom_range(300);
		shape  = $urandom_range(9);
		if (shape == 0) begin
			w.rain_lo = VALUE_W'(centre);
			w.rain_hi = VALUE_W'(centre);
		end else if (shape == 1) begin
			w.rain_lo = VALUE_W'(centre + span + 1);
			w.rain_hi = VALUE_W'(centre);
		end else begin
			w.rain_lo = VALUE_W'(centre - span);
			w.rain_hi = VALUE_W'(centre + span);
		end
		return w;
	endfunction

	// query aimed at the same pool and value neighbourhood
	function automatic item_word_t random_query();
		item_word_t w;
		w = random_noise();
		w.kind = KIND_QUERY;
		if ($urandom_range(99) < 15)
			return w;
		w.landuse     = LANDUSE_W'($urandom_range(7));
		w.landuse_any = ($urandom_range(99) < 10);
		w.query_temp  = VALUE_W'(int'($urandom_range(800)) - 400);
		w.query_rain  = VALUE_W'($urandom_range(1400));
		return w;
	endfunction

	function automatic step_row_t w_row(input int slot, input int lu, input bit any,
	                                    input int tlo, input int thi, input int rlo,
	                                    input int rhi, input int cls);
		step_row_t row;
		row.set_count    = 0;
		row.count        = '0;
		row.w            = '0;
		row.w.kind       = KIND_WRITE;
		row.w.slot       = SLOT_W'(slot);
		row.w.landuse    = LANDUSE_W'(lu);
		row.w.landuse_any = any;
		row.w.temp_lo    = VALUE_W'(tlo);
		row.w.temp_hi    = VALUE_W'(thi);
		row.w.rain_lo    = VALUE_W'(rlo);
		row.w.rain_hi    = VALUE_W'(rhi);
		row.w.class_code = CLASS_W'(cls);
		row.typed        = 0;
		row.want         = '0;
		return row;
	endfunction

	// cnt < 0 keeps the current rule count
	function automatic step_row_t q_row(input int cnt, input int lu, input bit any,
	                                    input int qt, input int qr, input bit typed,
	                                    input bit f, input int cls, input int hs);
		step_row_t row;
		row.set_count     = (cnt >= 0);
		row.count         = COUNT_W'(cnt);
		row.w             = '0;
		row.w.kind        = KIND_QUERY;
		row.w.landuse     = LANDUSE_W'(lu);
		row.w.landuse_any = any;
		row.w.query_temp  = VALUE_W'(qt);
		row.w.query_rain  = VALUE_W'(qr);
		row.typed         = typed;
		row.want.found        = f;
		row.want.result_class = CLASS_W'(cls);
		row.want.hit_slot     = SLOT_W'(hs);
		return row;
	endfunction

	// append one row to the directed table
	function automatic void add_step(input step_row_t row);
		directed_steps.insert(directed_steps.size(), row);
	endfunction

	// offer one word, wait for acceptance, then update the shadow
	task automatic send_word(input item_word_t w, input bit typed, input answer_t want);
		rule_t r;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			item_bus.valid = 1'b0;
			@(negedge clk);
		end
		item_bus.kind        = w.kind;
		item_bus.slot        = w.slot;
		item_bus.landuse     = w.landuse;
		item_bus.landuse_any = w.landuse_any;
		item_bus.temp_lo     = w.temp_lo;
		item_bus.temp_hi     = w.temp_hi;
		item_bus.rain_lo     = w.rain_lo;
		item_bus.rain_hi     = w.rain_hi;
		item_bus.class_code  = w.class_code;
		item_bus.query_temp  = w.query_temp;
		item_bus.query_rain  = w.query_rain;
		item_bus.valid       = 1'b1;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		words_sent++;
		if (w.kind == KIND_WRITE) begin
			if (w.slot < RULE_SLOTS) begin
				r.landuse     = w.landuse;
				r.landuse_any = w.landuse_any;
				r.temp_lo     = w.temp_lo;
				r.temp_hi     = w.temp_hi;
				r.rain_lo     = w.rain_lo;
				r.rain_hi     = w.rain_hi;
				r.class_code  = w.class_code;
				rule_table[w.slot]   = r;
				slot_written[w.slot] = 1'b1;
			end
		end else begin
			queries_sent++;
			pending_answers.insert(pending_answers.size(), typed ? want : classify(w));
		end
		@(negedge clk);
	endtask

	// stop offering and let every outstanding answer come back
	task automatic wait_drained();
		item_bus.valid = 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_count(input logic [COUNT_W-1:0] n);
		cfg_we   = 1'b1;
		cfg_data = n;
		@(negedge clk);
		cfg_we     = 1'b0;
		rule_count = n;
		settings_used++;
	endtask

	// result taker: random stalls, quiet stretches and one long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready = 1'b0;
			end else begin
				result_bus.ready = steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// score each accepted answer against the oldest expectation
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			got.found        = result_bus.found;
			got.result_class = result_bus.result_class;
			got.hit_slot     = result_bus.hit_slot;
			if (got.found === 1'b1)
				hits_seen++;
			else
				misses_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: stray answer: found=%0d class=%0d slot=%0d",
					         $time, got.found, got.result_class, got.hit_slot);
			end else begin
				want = pending_answers.pop_front();
				if (got.found !== want.found || got.result_class !== want.result_class ||
				    got.hit_slot !== want.hit_slot) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected found/class/slot %0d/%0d/%0d, got %0d/%0d/%0d",
						         $time, want.found, want.result_class, want.hit_slot,
						         got.found, got.result_class, got.hit_slot);
				end
			end
		end
	end

	// stimulus
	initial begin
		answer_t            none;
		logic [COUNT_W-1:0] n;
		int                 phase;
		int                 len;
		int                 lim;
		int                 pick;
		none = '0;

		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		item_bus.valid       = 1'b0;
		item_bus.kind        = KIND_WRITE;
		item_bus.slot        = '0;
		item_bus.landuse     = '0;
		item_bus.landuse_any = 1'b0;
		item_bus.temp_lo     = '0;
		item_bus.temp_hi     = '0;
		item_bus.rain_lo     = '0;
		item_bus.rain_hi     = '0;
		item_bus.class_code  = '0;
		item_bus.query_temp  = '0;
		item_bus.query_rain  = '0;
		for (int i = 0; i < RULE_SLOTS; i++)
			slot_written[i] = 1'b0;

		// directed rows
		// full-range rule, inverted window, range edges, wildcard with don't-care ranges
		add_step(w_row(0, 4095, 0, -32768, 32767, 0, 65535, 4095));
		add_step(w_row(1, 7, 0, 50, -50, 9, 9, 2));
		add_step(w_row(2, 7, 0, -32768, -32767, 65534, 65535, 3));
		add_step(w_row(3, 0, 1, 100, 100, 5, 5, 1));
		add_step(w_row(255, 12, 0, -200, 200, 100, 200, 2748));
		// empty scan after reset
		add_step(q_row(0, 0, 0, 0, 0, 1, 0, 0, 0));
		add_step(q_row(1, 4095, 0, 32767, 65535, 1, 1, 4095, 0));
		add_step(q_row(-1, 4095, 0, -32768, 0, 1, 1, 4095, 0));
		add_step(q_row(-1, 3, 0, 0, 0, 1, 0, 0, 0));
		add_step(q_row(-1, 3, 1, 0, 0, 1, 1, 4095, 0));
		// inverted window never matches
		add_step(q_row(3, 7, 0, 0, 0, 1, 0, 0, 0));
		add_step(q_row(-1, 7, 0, -32768, 65535, 1, 1, 3, 2));
		add_step(q_row(-1, 7, 0, -32767, 65533, 1, 0, 0, 0));
		add_step(q_row(4, 100, 0, 1234, 999, 1, 1, 1, 3));
		add_step(q_row(-1, 4095, 1, -1, 1, 0, 0, 0, 0));
		// overwrite the wildcard rule, then probe the new temperature bound
		add_step(w_row(3, 9, 0, -10, 10, 0, 0, 5));
		add_step(q_row(-1, 9, 0, 10, 40000, 1, 1, 5, 3));
		add_step(q_row(-1, 9, 0, 11, 0, 1, 0, 0, 0));
		add_step(q_row(-1, 9, 0, -10, 65535, 0, 0, 0, 0));

		// reset
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].set_count) begin
				wait_drained();
				set_count(directed_steps[i].count);
			end
			send_word(directed_steps[i].w, directed_steps[i].typed, directed_steps[i].want);
		end

		// random phases, each under one rule count
		phase = 0;
		while (words_sent < TARGET_WORDS) begin
			wait_drained();
			pick = $urandom_range(99);
			if (phase == 0)
				n = COUNT_W'(RULE_SLOTS);
			else if (phase == 1)
				n = COUNT_W'(MAX_COUNT);
			else if (pick < 8)
				n = '0;
			else if (pick < 18)
				n = COUNT_W'(RULE_SLOTS);
			else if (pick < 22)
				n = COUNT_W'($urandom_range(RULE_SLOTS + 1, MAX_COUNT));
			else
				n = COUNT_W'($urandom_range(1, 24));
			set_count(n);
			steady = (phase >= 5 && phase <= 7);

			// scanned slots must hold a rule before any query reads them
			lim = (n > RULE_SLOTS) ? RULE_SLOTS : int'(n);
			for (int s = 0; s < lim; s++)
				if (!slot_written[s])
					send_word(random_rule(s), 0, none);

			// long result hold-off while words keep coming
			if (phase == 3)
				hold_req = 1;

			len = $urandom_range(30, 90);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 55)
					send_word(random_query(), 0, none);
				else
					send_word(random_rule($urandom_range(RULE_SLOTS - 1)), 0, none);
			end
			phase++;
		end
		steady = 0;

		// wait out the answers, then keep watching for stray words
		wait_drained();
		repeat (RULE_SLOTS + 8) @(negedge clk);

		$display("%0d words sent, %0d of them queries: %0d hits and %0d misses scored",
		         words_sent, queries_sent, hits_seen, misses_seen);
		$display("%0d rule-count settings from empty to over-range, %0d-cycle result hold-off",
		         settings_used, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
